// ----- rtl/core/tspp_pkg.sv -----
// ----------------------------------------------------------------------------
// tspp_pkg: shared types and constants of the PAT/PMT section parser
// Holds the parse steps, phases, result kinds, the result record and the
// stream type classifier.
// ----------------------------------------------------------------------------
package tspp_pkg;

  localparam int MaxPrograms = 64;
  localparam int PacketBytes = 188;
  localparam int TdataBits   = 40;

  typedef enum logic [1:0] {
    PH_PAT  = 2'd0,
    PH_PMT  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_B1, ST_B2, ST_B3, ST_ADAPT_LEN, ST_ADAPT_SKIP, ST_PTR, ST_PTR_SKIP, ST_TID,
    ST_LEN_HI, ST_LEN_LO, ST_ID_HI, ST_ID_LO, ST_VER, ST_SECNUM, ST_LASTNUM,
    ST_PAT_E0, ST_PAT_E1, ST_PAT_E2, ST_PAT_E3, ST_PCR_HI, ST_PCR_LO, ST_PIL_HI,
    ST_PIL_LO, ST_DESC_SKIP, ST_ES_TYPE, ST_ES_PID_HI, ST_ES_PID_LO, ST_ES_LEN_HI,
    ST_ES_LEN_LO, ST_ES_SKIP, ST_TAIL, ST_SKIP
  } step_t;

  typedef enum logic [2:0] {
    KIND_PAT      = 3'd0,
    KIND_PMT      = 3'd1,
    KIND_ES       = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] program_number;
    logic [12:0] pid_value;
    logic [7:0]  stream_type;
    logic [2:0]  stream_class;
    logic        last_of_run;
  } result_t;

  // Results produced by one byte: up to two, the first always in slot a.
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t slot_a;
    result_t slot_b;
  } push_t;

  // Maps a raw stream type to its class code.
  function automatic logic [2:0] classify(input logic [7:0] t);
    logic [2:0] c;
    case (t)
      8'h01:   c = 3'd0;
      8'h02:   c = 3'd1;
      8'h03:   c = 3'd2;
      8'h04:   c = 3'd3;
      8'h05:   c = 3'd4;
      8'h06:   c = 3'd5;
      8'h07:   c = 3'd5;
      8'h81:   c = 3'd6;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/tspp_parse.sv -----
// ----------------------------------------------------------------------------
// tspp_parse: byte-level packet and section parser
// Walks each 188-byte packet, checks the header and section fields, keeps
// the program table and produces up to two results for each byte.
// ----------------------------------------------------------------------------
module tspp_parse #(
  parameter int MAX_PROGRAMS = tspp_pkg::MaxPrograms
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            packet_start,
  output tspp_pkg::push_t push
);

  localparam int AW = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
  localparam logic [7:0] LastPos = 8'(tspp_pkg::PacketBytes - 1);
  localparam logic [6:0] MaxEntries = 7'(MAX_PROGRAMS);

  tspp_pkg::phase_t phase, phase_next;
  tspp_pkg::step_t  step, step_next;
  logic [7:0]  pos, pos_next, pos_eff;
  logic [11:0] skip, skip_next;
  logic [9:0]  rem, rem_next;
  logic [6:0]  entry_count, entry_count_next;
  logic [6:0]  cur, cur_next;
  logic        aw_pat, aw_pat_next, aw_pmt, aw_pmt_next;
  logic [15:0] secpair, secpair_next;
  logic [15:0] fa, fa_next;

  logic [28:0] table_mem [MAX_PROGRAMS];
  logic [28:0] rd_entry;
  logic        wr_en;
  logic [28:0] wr_data;

  logic        emit_v, done_v;
  tspp_pkg::result_t emit_r, done_r;

  // Program table: one write port, one registered read at the current entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[entry_count[AW-1:0]] <= wr_data;
    end
    rd_entry <= table_mem[cur[AW-1:0]];
  end

  // Parser next-state logic for one byte.
  always_comb begin
    logic [1:0]  am;
    logic [12:0] pid;
    logic [12:0] want;
    logic        waitf;
    logic [9:0]  len;
    logic [6:0]  cur_inc;

    phase_next = phase; step_next = step; skip_next = skip; rem_next = rem;
    entry_count_next = entry_count; cur_next = cur; aw_pat_next = aw_pat;
    aw_pmt_next = aw_pmt; secpair_next = secpair; fa_next = fa;
    wr_en = 1'b0; wr_data = 29'd0;
    emit_v = 1'b0; emit_r = '0; done_v = 1'b0; done_r = '0;
    done_r.kind = tspp_pkg::KIND_DONE;
    am = 2'd0; pid = 13'd0; want = 13'd0; waitf = 1'b0; len = 10'd0; cur_inc = 7'd0;
    pos_eff = packet_start ? 8'd0 : pos;
    pos_next = (pos_eff == LastPos) ? 8'd0 : pos_eff + 8'd1;

    if (phase != tspp_pkg::PH_DONE) begin
      if (pos_eff == 8'd0) begin
        step_next = tspp_pkg::ST_B1;
      end else begin
        if (step > tspp_pkg::ST_LEN_LO && step != tspp_pkg::ST_SKIP && rem != 10'd0) begin
          rem_next = rem - 10'd1;
        end
        case (step)
          tspp_pkg::ST_B1: begin
            fa_next = {8'd0, data_byte};
            step_next = tspp_pkg::ST_B2;
          end
          tspp_pkg::ST_B2: begin
            pid = {fa[4:0], data_byte};
            want = (phase == tspp_pkg::PH_PAT) ? 13'd0 : rd_entry[12:0];
            waitf = (phase == tspp_pkg::PH_PAT) ? aw_pat : aw_pmt;
            if (pid != want || fa[7] || (waitf && !fa[6])) begin
              step_next = tspp_pkg::ST_SKIP;
            end else begin
              step_next = tspp_pkg::ST_B3;
            end
          end
          tspp_pkg::ST_B3: begin
            am = data_byte[5:4];
            if (am == 2'd0 || am == 2'd2) step_next = tspp_pkg::ST_SKIP;
            else if (am == 2'd3) step_next = tspp_pkg::ST_ADAPT_LEN;
            else step_next = tspp_pkg::ST_PTR;
          end
          tspp_pkg::ST_ADAPT_LEN: begin
            skip_next = {4'd0, data_byte};
            step_next = (data_byte != 8'd0) ? tspp_pkg::ST_ADAPT_SKIP : tspp_pkg::ST_PTR;
          end
          tspp_pkg::ST_ADAPT_SKIP: begin
            skip_next = skip - 12'd1;
            if (skip_next == 12'd0) step_next = tspp_pkg::ST_PTR;
          end
          tspp_pkg::ST_PTR: begin
            skip_next = {4'd0, data_byte};
            step_next = (data_byte != 8'd0) ? tspp_pkg::ST_PTR_SKIP : tspp_pkg::ST_TID;
          end
          tspp_pkg::ST_PTR_SKIP: begin
            skip_next = skip - 12'd1;
            if (skip_next == 12'd0) step_next = tspp_pkg::ST_TID;
          end
          tspp_pkg::ST_TID: begin
            if (data_byte == ((phase == tspp_pkg::PH_PAT) ? 8'd0 : 8'd2)) begin
              step_next = tspp_pkg::ST_LEN_HI;
            end else begin
              step_next = tspp_pkg::ST_SKIP;
            end
          end
          tspp_pkg::ST_LEN_HI: begin
            if (data_byte[7:6] != 2'b10 || data_byte[3:2] != 2'b00) begin
              step_next = tspp_pkg::ST_SKIP;
            end else begin
              fa_next = {6'd0, data_byte[1:0], 8'd0};
              step_next = tspp_pkg::ST_LEN_LO;
            end
          end
          tspp_pkg::ST_LEN_LO: begin
            len = {fa[9:8], data_byte};
            if (len > 10'h3fd) begin
              step_next = tspp_pkg::ST_SKIP;
            end else begin
              rem_next = len;
              step_next = tspp_pkg::ST_ID_HI;
            end
          end
          tspp_pkg::ST_ID_HI: step_next = tspp_pkg::ST_ID_LO;
          tspp_pkg::ST_ID_LO: step_next = tspp_pkg::ST_VER;
          tspp_pkg::ST_VER: begin
            step_next = data_byte[0] ? tspp_pkg::ST_SECNUM : tspp_pkg::ST_SKIP;
          end
          tspp_pkg::ST_SECNUM: begin
            secpair_next = {data_byte, 8'd0};
            step_next = tspp_pkg::ST_LASTNUM;
          end
          tspp_pkg::ST_LASTNUM: begin
            secpair_next = {secpair[15:8], data_byte};
            step_next = (phase == tspp_pkg::PH_PAT) ? tspp_pkg::ST_PAT_E0
                                                    : tspp_pkg::ST_PCR_HI;
          end
          tspp_pkg::ST_PAT_E0: begin
            if (rem >= 10'd8) begin
              fa_next = {data_byte, 8'd0};
              step_next = tspp_pkg::ST_PAT_E1;
            end else begin
              step_next = tspp_pkg::ST_TAIL;
            end
          end
          tspp_pkg::ST_PAT_E1: begin
            fa_next = {fa[15:8], data_byte};
            step_next = tspp_pkg::ST_PAT_E2;
          end
          tspp_pkg::ST_PAT_E2: begin
            skip_next = {7'd0, data_byte[4:0]};
            step_next = tspp_pkg::ST_PAT_E3;
          end
          tspp_pkg::ST_PAT_E3: begin
            pid = {skip[4:0], data_byte};
            emit_v = 1'b1;
            emit_r.program_number = fa;
            emit_r.pid_value = pid;
            if (entry_count < MaxEntries) begin
              wr_en = 1'b1;
              wr_data = {fa, pid};
              entry_count_next = entry_count + 7'd1;
              emit_r.kind = tspp_pkg::KIND_PAT;
            end else begin
              emit_r.kind = tspp_pkg::KIND_OVERFLOW;
            end
            step_next = tspp_pkg::ST_PAT_E0;
          end
          tspp_pkg::ST_PCR_HI: begin
            fa_next = {3'd0, data_byte[4:0], 8'd0};
            step_next = tspp_pkg::ST_PCR_LO;
          end
          tspp_pkg::ST_PCR_LO: begin
            emit_v = 1'b1;
            emit_r.kind = tspp_pkg::KIND_PMT;
            emit_r.program_number = rd_entry[28:13];
            emit_r.pid_value = {fa[12:8], data_byte};
            step_next = tspp_pkg::ST_PIL_HI;
          end
          tspp_pkg::ST_PIL_HI: begin
            fa_next = {4'd0, data_byte[3:0], 8'd0};
            step_next = tspp_pkg::ST_PIL_LO;
          end
          tspp_pkg::ST_PIL_LO: begin
            skip_next = {fa[11:8], data_byte};
            step_next = (skip_next != 12'd0) ? tspp_pkg::ST_DESC_SKIP
                                             : tspp_pkg::ST_ES_TYPE;
          end
          tspp_pkg::ST_DESC_SKIP: begin
            skip_next = skip - 12'd1;
            if (skip_next == 12'd0) step_next = tspp_pkg::ST_ES_TYPE;
          end
          tspp_pkg::ST_ES_TYPE: begin
            if (rem > 10'd4) begin
              fa_next = {8'd0, data_byte};
              step_next = tspp_pkg::ST_ES_PID_HI;
            end else begin
              step_next = tspp_pkg::ST_TAIL;
            end
          end
          tspp_pkg::ST_ES_PID_HI: begin
            skip_next = {7'd0, data_byte[4:0]};
            step_next = tspp_pkg::ST_ES_PID_LO;
          end
          tspp_pkg::ST_ES_PID_LO: begin
            emit_v = 1'b1;
            emit_r.kind = tspp_pkg::KIND_ES;
            emit_r.program_number = rd_entry[28:13];
            emit_r.pid_value = {skip[4:0], data_byte};
            emit_r.stream_type = fa[7:0];
            emit_r.stream_class = tspp_pkg::classify(fa[7:0]);
            step_next = tspp_pkg::ST_ES_LEN_HI;
          end
          tspp_pkg::ST_ES_LEN_HI: begin
            fa_next = {4'd0, data_byte[3:0], 8'd0};
            step_next = tspp_pkg::ST_ES_LEN_LO;
          end
          tspp_pkg::ST_ES_LEN_LO: begin
            skip_next = {fa[11:8], data_byte};
            step_next = (skip_next != 12'd0) ? tspp_pkg::ST_ES_SKIP
                                             : tspp_pkg::ST_ES_TYPE;
          end
          tspp_pkg::ST_ES_SKIP: begin
            skip_next = skip - 12'd1;
            if (skip_next == 12'd0) step_next = tspp_pkg::ST_ES_TYPE;
          end
          default: ;
        endcase
      end

      // End of packet: close the section and move through the phases.
      if (pos_eff == LastPos && step_next >= tspp_pkg::ST_PAT_E0 &&
          step_next != tspp_pkg::ST_SKIP) begin
        if (phase == tspp_pkg::PH_PAT) begin
          aw_pat_next = 1'b0;
          if (secpair_next[15:8] == secpair_next[7:0]) begin
            cur_next = 7'd0;
            if (entry_count_next == 7'd0) begin
              phase_next = tspp_pkg::PH_DONE;
              done_v = 1'b1;
            end else begin
              phase_next = tspp_pkg::PH_PMT;
            end
          end
        end else begin
          aw_pmt_next = 1'b0;
          if (secpair_next[15:8] == secpair_next[7:0]) begin
            cur_inc = cur + 7'd1;
            cur_next = cur_inc;
            if (cur_inc >= entry_count_next) begin
              phase_next = tspp_pkg::PH_DONE;
              done_v = 1'b1;
            end
          end
        end
      end
    end
  end

  // Pack the results of this byte into the two push slots.
  always_comb begin
    push = '0;
    push.push_a = accept && (emit_v || done_v);
    push.push_b = accept && emit_v && done_v;
    push.slot_a = emit_v ? emit_r : done_r;
    push.slot_a.last_of_run = !(emit_v && done_v);
    push.slot_b = done_r;
    push.slot_b.last_of_run = 1'b1;
  end

  // Parser state registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tspp_pkg::PH_PAT;
      step <= tspp_pkg::ST_B1;
      pos <= 8'd0;
      skip <= 12'd0;
      rem <= 10'd0;
      entry_count <= 7'd0;
      cur <= 7'd0;
      aw_pat <= 1'b1;
      aw_pmt <= 1'b1;
      secpair <= 16'd0;
      fa <= 16'd0;
    end else if (accept) begin
      phase <= phase_next;
      step <= step_next;
      pos <= pos_next;
      skip <= skip_next;
      rem <= rem_next;
      entry_count <= entry_count_next;
      cur <= cur_next;
      aw_pat <= aw_pat_next;
      aw_pmt <= aw_pmt_next;
      secpair <= secpair_next;
      fa <= fa_next;
    end
  end

endmodule

// ----- rtl/core/tspp_queue.sv -----
// ----------------------------------------------------------------------------
// tspp_queue: four-entry result queue
// Takes up to two results in a cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module tspp_queue (
  input  logic              clk,
  input  logic              rst,
  input  tspp_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tspp_pkg::result_t out_result,
  output logic [2:0]        count
);

  tspp_pkg::result_t store [4];
  logic [1:0] wp, rp;
  logic       pop;
  logic [2:0] n_in;

  assign pop = out_valid && out_ready;
  assign n_in = {2'd0, push.push_a} + {2'd0, push.push_b};
  assign room = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign out_result = store[rp];

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.push_a) store[wp] <= push.slot_a;
    if (push.push_b) store[wp + 2'd1] <= push.slot_b;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0;
      rp <= 2'd0;
      count <= 3'd0;
    end else begin
      wp <= wp + n_in[1:0];
      if (pop) rp <= rp + 2'd1;
      count <= count + n_in - {2'd0, pop};
    end
  end

endmodule

// ----- rtl/core/ts_pat_pmt_section_parser.sv -----
// ----------------------------------------------------------------------------
// ts_pat_pmt_section_parser: PAT and PMT section parser for transport streams
// Parses the PAT into a program table, then each listed PMT, and reports
// program entries, PCR PIDs, elementary streams and the end of the parse.
//
//   channel | direction | tdata                          | tuser          | tlast
//   s_axis  | in        | data_byte                      | packet_start   | -
//   m_axis  | out       | program_number, pid_value,     | kind           | last_of_run
//           |           | stream_type, stream_class      |                |
//
// One byte is taken per cycle while there is room; its results are registered.
// A byte yields at most two results, which queue in a four-entry buffer;
// input is held off while fewer than two places are free.
// Reset is synchronous and returns the parser to the PAT phase.
// The program table is not cleared; only written entries are ever used.
// ----------------------------------------------------------------------------
module ts_pat_pmt_section_parser #(
  parameter int MAX_PROGRAMS = tspp_pkg::MaxPrograms
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] packet_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] program_number, [28:16] pid_value,
                                      // [36:29] stream_type, [39:37] stream_class
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  logic              accept;
  logic              room;
  logic [2:0]        count;
  tspp_pkg::push_t   push;
  tspp_pkg::result_t res;

  assign s_axis_tready = room;
  assign accept = s_axis_tvalid && room;

  tspp_parse #(.MAX_PROGRAMS(MAX_PROGRAMS)) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_axis_tdata),
    .packet_start (s_axis_tuser[0]),
    .push         (push)
  );

  tspp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res),
    .count      (count)
  );

  // Output packing.
  assign m_axis_tdata = {res.stream_class, res.stream_type, res.pid_value,
                         res.program_number};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_of_run;

  // The queue never holds more than its four entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue over-filled");

  // Results only come from an accepted byte.
  a_push_accept: assert property (@(posedge clk) disable iff (rst)
    push.push_a |-> accept)
    else $error("result pushed without a byte transfer");

  // A second result from one byte is always the completion report.
  a_second_done: assert property (@(posedge clk) disable iff (rst)
    push.push_b |-> (push.push_a && push.slot_b.kind == tspp_pkg::KIND_DONE))
    else $error("unexpected second result");

endmodule
